[rtl/igmp_pkg.sv]
package igmp_pkg;

    // field widths
    localparam int GROUP_W   = 32;
    localparam int IFACE_W   = 4;
    localparam int DELAY_W   = 6;
    localparam int FUNC_W    = 3;
    localparam int STATUS_W  = 3;
    localparam int CFG_IDX_W = 1;

    // multicast class prefix (top nibble of a group address)
    localparam logic [3:0] MCAST_PREFIX = 4'hE;

    // 224.0.0.1
    localparam logic [GROUP_W-1:0] ALL_HOSTS_RESET = 32'hE000_0001;

    typedef enum logic [FUNC_W-1:0] {
        FN_QUERY  = 3'd0,
        FN_REPORT = 3'd1,
        FN_JOIN   = 3'd2,
        FN_LEAVE  = 3'd3,
        FN_TICK   = 3'd4
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK         = 3'd0,
        STAT_LOOPBACK   = 3'd1,
        STAT_BAD_QUERY  = 3'd2,
        STAT_BAD_REPORT = 3'd3,
        STAT_OWN_REPORT = 3'd4,
        STAT_TABLE_FULL = 3'd5,
        STAT_NOT_FOUND  = 3'd6
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ALL_HOSTS = 1'b0,
        CFG_LOOPBACK  = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [GROUP_W-1:0] all_hosts_group;
        logic [IFACE_W-1:0] loopback_iface;
    } cfg_t;

    // one membership table word
    typedef struct packed {
        logic [GROUP_W-1:0] group;
        logic [IFACE_W-1:0] iface;
        logic [DELAY_W-1:0] timer;
    } entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_WALK,
        S_FINISH,
        S_EMIT
    } eng_state_t;

endpackage

[rtl/igmp_ifs.sv]
interface igmp_item_if import igmp_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [FUNC_W-1:0]  func;
    logic [IFACE_W-1:0] iface;
    logic [GROUP_W-1:0] group_addr;
    logic [GROUP_W-1:0] dst_addr;
    logic [DELAY_W-1:0] delay;

    modport source (output valid, func, iface, group_addr, dst_addr, delay, input ready);
    modport sink   (input valid, func, iface, group_addr, dst_addr, delay, output ready);
endinterface

interface igmp_result_if import igmp_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                is_report;
    logic [GROUP_W-1:0]  report_group;
    logic [IFACE_W-1:0]  report_iface;
    logic [STATUS_W-1:0] status;
    logic                last;

    modport source (output valid, is_report, report_group, report_iface, status, last,
                    input ready);
    modport sink   (input valid, is_report, report_group, report_iface, status, last,
                    output ready);
endinterface

interface igmp_cfg_if import igmp_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [GROUP_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/igmp_ram.sv]
module igmp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/igmp_engine.sv]
module igmp_engine import igmp_pkg::*; #(
    parameter int ENTRIES = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  cfg_t          cfg_regs,
    igmp_item_if.sink     item,
    igmp_result_if.source result
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    eng_state_t state_reg, state_next;

    // latched item
    logic [FUNC_W-1:0]  func_reg;
    logic [IFACE_W-1:0] iface_reg;
    logic [GROUP_W-1:0] group_reg;
    logic [GROUP_W-1:0] dst_reg;
    logic [DELAY_W-1:0] delay_reg;

    // walk bookkeeping
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               found_reg, found_next;
    logic               free_found_reg, free_found_next;
    logic [IDX_W-1:0]   free_idx_reg, free_idx_next;
    logic               still_run_reg, still_run_next;

    // tick report held back one step so that the final one can carry last
    logic               pend_valid_reg, pend_valid_next;
    logic [GROUP_W-1:0] pend_group_reg, pend_group_next;
    logic [IFACE_W-1:0] pend_iface_reg, pend_iface_next;

    // table state outside the memory
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic               running_reg, running_next;

    // final beat of the item
    logic               res_report_reg, res_report_next;
    logic [GROUP_W-1:0] res_group_reg, res_group_next;
    logic [IFACE_W-1:0] res_iface_reg, res_iface_next;
    status_t            res_status_reg, res_status_next;

    // output register
    logic                out_valid_reg, out_valid_next;
    logic                out_report_reg, out_report_next;
    logic [GROUP_W-1:0]  out_group_reg, out_group_next;
    logic [IFACE_W-1:0]  out_iface_reg, out_iface_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic                out_last_reg, out_last_next;

    // memory port
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    entry_t           ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    entry_t           ram_rdata;

    entry_t             cur;
    logic               cur_valid;
    logic               cur_match;
    logic               out_free;
    logic [DELAY_W-1:0] dec_timer;

    igmp_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign item.ready = (state_reg == S_IDLE);

    assign result.valid        = out_valid_reg;
    assign result.is_report    = out_report_reg;
    assign result.report_group = out_group_reg;
    assign result.report_iface = out_iface_reg;
    assign result.status       = out_status_reg;
    assign result.last         = out_last_reg;

    // entry under inspection during the walk
    assign cur       = ram_rdata;
    assign cur_valid = valid_reg[idx_reg];
    assign cur_match = cur_valid && (cur.group == group_reg) && (cur.iface == iface_reg);
    assign out_free  = !out_valid_reg || result.ready;
    assign dec_timer = cur.timer - DELAY_W'(1);

    // sequencer: check, walk the table, finish, emit
    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        found_next      = found_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        still_run_next  = still_run_reg;
        pend_valid_next = pend_valid_reg;
        pend_group_next = pend_group_reg;
        pend_iface_next = pend_iface_reg;
        valid_next      = valid_reg;
        running_next    = running_reg;
        res_report_next = res_report_reg;
        res_group_next  = res_group_reg;
        res_iface_next  = res_iface_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        out_report_next = out_report_reg;
        out_group_next  = out_group_reg;
        out_iface_next  = out_iface_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg;
        ram_wdata       = cur;
        ram_raddr       = idx_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item.valid)
                begin
                    state_next = S_CHECK;
                end
            end

            S_CHECK:
            begin
                idx_next        = '0;
                found_next      = 1'b0;
                free_found_next = 1'b0;
                still_run_next  = 1'b0;
                pend_valid_next = 1'b0;
                res_report_next = 1'b0;
                res_group_next  = '0;
                res_iface_next  = '0;
                res_status_next = STAT_OK;
                ram_raddr       = '0;
                state_next      = S_EMIT;
                unique case (func_reg) inside
                    FN_QUERY:
                    begin
                        if (iface_reg == cfg_regs.loopback_iface)
                        begin
                            res_status_next = STAT_LOOPBACK;
                        end
                        else if (dst_reg != cfg_regs.all_hosts_group)
                        begin
                            res_status_next = STAT_BAD_QUERY;
                        end
                        else
                        begin
                            state_next = S_WALK;
                        end
                    end
                    FN_REPORT:
                    begin
                        if (iface_reg == cfg_regs.loopback_iface)
                        begin
                            res_status_next = STAT_LOOPBACK;
                        end
                        else if ((group_reg[GROUP_W-1 -: 4] != MCAST_PREFIX) ||
                                 (group_reg != dst_reg))
                        begin
                            res_status_next = STAT_BAD_REPORT;
                        end
                        else
                        begin
                            state_next = S_WALK;
                        end
                    end
                    FN_JOIN, FN_LEAVE:
                    begin
                        state_next = S_WALK;
                    end
                    FN_TICK:
                    begin
                        if (running_reg)
                        begin
                            state_next = S_WALK;
                        end
                    end
                    default:
                    begin
                        state_next = S_EMIT;
                    end
                endcase
            end

            S_WALK:
            begin
                ram_raddr = (idx_reg == LAST_IDX) ? idx_reg : IDX_W'(idx_reg + 1'b1);
                unique case (func_reg)
                    FN_QUERY:
                    begin
                        // start idle timers on the arrival interface
                        if (cur_valid && (cur.iface == iface_reg) && (cur.timer == '0) &&
                            (cur.group != cfg_regs.all_hosts_group))
                        begin
                            ram_we          = 1'b1;
                            ram_wdata.timer = delay_reg;
                            running_next    = 1'b1;
                        end
                    end
                    FN_REPORT:
                    begin
                        // someone else reported: stop our timer
                        if (cur_match && !found_reg)
                        begin
                            found_next      = 1'b1;
                            ram_we          = 1'b1;
                            ram_wdata.timer = '0;
                        end
                    end
                    FN_JOIN:
                    begin
                        if (cur_match)
                        begin
                            found_next = 1'b1;
                        end
                        if (!cur_valid && !free_found_reg)
                        begin
                            free_found_next = 1'b1;
                            free_idx_next   = idx_reg;
                        end
                    end
                    FN_LEAVE:
                    begin
                        if (cur_match && !found_reg)
                        begin
                            found_next          = 1'b1;
                            valid_next[idx_reg] = 1'b0;
                        end
                    end
                    FN_TICK:
                    begin
                        if (cur_valid && (cur.timer != '0))
                        begin
                            if (dec_timer != '0)
                            begin
                                ram_we          = 1'b1;
                                ram_wdata.timer = dec_timer;
                                still_run_next  = 1'b1;
                            end
                            else if (pend_valid_reg && !out_free)
                            begin
                                // output busy: hold this entry and read it again
                                ram_raddr = idx_reg;
                            end
                            else
                            begin
                                if (pend_valid_reg)
                                begin
                                    out_valid_next  = 1'b1;
                                    out_report_next = 1'b1;
                                    out_group_next  = pend_group_reg;
                                    out_iface_next  = pend_iface_reg;
                                    out_status_next = STAT_OK;
                                    out_last_next   = 1'b0;
                                end
                                pend_valid_next = 1'b1;
                                pend_group_next = cur.group;
                                pend_iface_next = cur.iface;
                                ram_we          = 1'b1;
                                ram_wdata.timer = '0;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase

                // advance, or finish at the last entry, unless a tick beat is held back
                if (ram_raddr != idx_reg)
                begin
                    idx_next = IDX_W'(idx_reg + 1'b1);
                end
                else if ((idx_reg == LAST_IDX) &&
                         !((func_reg == FN_TICK) && cur_valid && (cur.timer != '0) &&
                           (dec_timer == '0) && pend_valid_reg && !out_free))
                begin
                    state_next = S_FINISH;
                end
            end

            S_FINISH:
            begin
                state_next = S_EMIT;
                unique case (func_reg)
                    FN_REPORT:
                    begin
                        res_status_next = found_reg ? STAT_OWN_REPORT : STAT_OK;
                    end
                    FN_JOIN:
                    begin
                        if (found_reg)
                        begin
                            res_status_next = STAT_OK;
                        end
                        else if (!free_found_reg)
                        begin
                            res_status_next = STAT_TABLE_FULL;
                        end
                        else
                        begin
                            // record the membership in the first free slot
                            ram_we                   = 1'b1;
                            ram_waddr                = free_idx_reg;
                            ram_wdata.group          = group_reg;
                            ram_wdata.iface          = iface_reg;
                            ram_wdata.timer          = '0;
                            valid_next[free_idx_reg] = 1'b1;
                            if (iface_reg == cfg_regs.loopback_iface)
                            begin
                                res_status_next = STAT_LOOPBACK;
                            end
                            else if (group_reg != cfg_regs.all_hosts_group)
                            begin
                                ram_wdata.timer = delay_reg;
                                running_next    = 1'b1;
                                res_report_next = 1'b1;
                                res_group_next  = group_reg;
                                res_iface_next  = iface_reg;
                            end
                        end
                    end
                    FN_LEAVE:
                    begin
                        res_status_next = found_reg ? STAT_OK : STAT_NOT_FOUND;
                    end
                    FN_TICK:
                    begin
                        running_next = still_run_reg;
                        if (pend_valid_reg)
                        begin
                            res_report_next = 1'b1;
                            res_group_next  = pend_group_reg;
                            res_iface_next  = pend_iface_reg;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_report_next = res_report_reg;
                    out_group_next  = res_group_reg;
                    out_iface_next  = res_iface_reg;
                    out_status_next = res_status_reg;
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            valid_reg      <= '0;
            running_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            still_run_reg  <= 1'b0;
            idx_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            running_reg    <= running_next;
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
            found_reg      <= found_next;
            free_found_reg <= free_found_next;
            still_run_reg  <= still_run_next;
            idx_reg        <= idx_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            func_reg  <= item.func;
            iface_reg <= item.iface;
            group_reg <= item.group_addr;
            dst_reg   <= item.dst_addr;
            delay_reg <= (item.delay == '0) ? DELAY_W'(1) : item.delay;
        end
        free_idx_reg   <= free_idx_next;
        pend_group_reg <= pend_group_next;
        pend_iface_reg <= pend_iface_next;
        res_report_reg <= res_report_next;
        res_group_reg  <= res_group_next;
        res_iface_reg  <= res_iface_next;
        res_status_reg <= res_status_next;
        out_report_reg <= out_report_next;
        out_group_reg  <= out_group_next;
        out_iface_reg  <= out_iface_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

endmodule

[rtl/igmp_membership_report_timers.sv]
// IGMPv1 host membership report timers. Memberships (group, interface, report
// timer) live in a single-port-write, registered-read table memory; per-entry
// valid bits and the timers-running flag sit in flip-flops, so the table is
// usable right after reset with no clearing pass. One item is handled at a
// time. Queries, received reports, joins, leaves and ticks with timers running
// walk the table one entry per cycle through the memory read port; a tick that
// expires several timers stalls the walk whenever the result register is still
// full. Items settled by the header checks alone (loopback, bad query, bad
// report, tick with no timer running, unknown function) skip the walk and go
// straight to the result stage. Configuration writes are taken every cycle.
module igmp_membership_report_timers import igmp_pkg::*; #(
    parameter int ENTRIES = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    igmp_cfg_if.sink      cfg,
    igmp_item_if.sink     item,
    igmp_result_if.source result
);

    logic [GROUP_W-1:0] all_hosts_reg;
    logic [IFACE_W-1:0] loopback_reg;
    cfg_t               cfg_regs;

    assign cfg.ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            all_hosts_reg <= ALL_HOSTS_RESET;
            loopback_reg  <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                CFG_ALL_HOSTS: all_hosts_reg <= cfg.data;
                CFG_LOOPBACK:  loopback_reg  <= cfg.data[IFACE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg_regs.all_hosts_group = all_hosts_reg;
    assign cfg_regs.loopback_iface  = loopback_reg;

    igmp_engine #(
        .ENTRIES (ENTRIES)
    ) u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_regs (cfg_regs),
        .item     (item),
        .result   (result)
    );

endmodule

[bench/igmp_report_monitor.sv]
`timescale 1ns / 1ps

module igmp_report_monitor import igmp_pkg::*; #(
    parameter int NUM_ENTRIES = 16
) (
    input  logic   clk,
    input  logic   rst_n,
    igmp_cfg_if    cfg,
    igmp_item_if   item,
    igmp_result_if result,
    output int     errors,
    output int     pending
);

    typedef struct packed {
        logic                is_report;
        logic [GROUP_W-1:0]  group;
        logic [IFACE_W-1:0]  iface;
        logic [STATUS_W-1:0] status;
        logic                last;
    } report_beat_t;

    // predicted result beats, oldest first
    report_beat_t expected_beats[$];

    // shadow of the block's registers and membership table
    logic [GROUP_W-1:0] hosts_group;
    logic [IFACE_W-1:0] lo_iface;
    logic               held_valid [NUM_ENTRIES];
    logic [GROUP_W-1:0] held_group [NUM_ENTRIES];
    logic [IFACE_W-1:0] held_iface [NUM_ENTRIES];
    logic [DELAY_W-1:0] held_timer [NUM_ENTRIES];
    logic               timers_live;

    function automatic void queue_beat(input logic rep, input logic [GROUP_W-1:0] grp,
                                       input logic [IFACE_W-1:0] ifc, input status_t st,
                                       input logic fin);
        report_beat_t b;
        b.is_report = rep;
        b.group     = grp;
        b.iface     = ifc;
        b.status    = st;
        b.last      = fin;
        expected_beats.push_back(b);
    endfunction

    function automatic int find_membership(input logic [GROUP_W-1:0] grp,
                                           input logic [IFACE_W-1:0] ifc);
        int i;
        for (i = 0; i < NUM_ENTRIES; i++)
            if (held_valid[i] && held_group[i] == grp && held_iface[i] == ifc)
                return i;
        return -1;
    endfunction

    // work out the result beats of one accepted item and update the table
    function automatic void predict_membership(input logic [FUNC_W-1:0] fn,
                                               input logic [IFACE_W-1:0] ifc,
                                               input logic [GROUP_W-1:0] grp,
                                               input logic [GROUP_W-1:0] dst,
                                               input logic [DELAY_W-1:0] dly_in);
        logic [DELAY_W-1:0] dly;
        int i;
        int slot;
        int fired;
        dly   = (dly_in == '0) ? DELAY_W'(1) : dly_in;
        fired = 0;
        case (fn)
            FN_QUERY:
            begin
                if (ifc == lo_iface)
                    queue_beat(1'b0, '0, '0, STAT_LOOPBACK, 1'b1);
                else if (dst != hosts_group)
                    queue_beat(1'b0, '0, '0, STAT_BAD_QUERY, 1'b1);
                else
                begin
                    for (i = 0; i < NUM_ENTRIES; i++)
                    begin
                        if (held_valid[i] && held_iface[i] == ifc && held_timer[i] == '0 &&
                            held_group[i] != hosts_group)
                        begin
                            held_timer[i] = dly;
                            timers_live   = 1'b1;
                        end
                    end
                    queue_beat(1'b0, '0, '0, STAT_OK, 1'b1);
                end
            end
            FN_REPORT:
            begin
                if (ifc == lo_iface)
                    queue_beat(1'b0, '0, '0, STAT_LOOPBACK, 1'b1);
                else if (grp[GROUP_W-1 -: 4] != MCAST_PREFIX || grp != dst)
                    queue_beat(1'b0, '0, '0, STAT_BAD_REPORT, 1'b1);
                else
                begin
                    slot = find_membership(grp, ifc);
                    if (slot >= 0)
                    begin
                        held_timer[slot] = '0;
                        queue_beat(1'b0, '0, '0, STAT_OWN_REPORT, 1'b1);
                    end
                    else
                        queue_beat(1'b0, '0, '0, STAT_OK, 1'b1);
                end
            end
            FN_JOIN:
            begin
                slot = -1;
                if (find_membership(grp, ifc) >= 0)
                    queue_beat(1'b0, '0, '0, STAT_OK, 1'b1);
                else
                begin
                    for (i = 0; i < NUM_ENTRIES && slot < 0; i++)
                        if (!held_valid[i])
                            slot = i;
                    if (slot < 0)
                        queue_beat(1'b0, '0, '0, STAT_TABLE_FULL, 1'b1);
                    else
                    begin
                        held_valid[slot] = 1'b1;
                        held_group[slot] = grp;
                        held_iface[slot] = ifc;
                        held_timer[slot] = '0;
                        if (ifc == lo_iface)
                            queue_beat(1'b0, '0, '0, STAT_LOOPBACK, 1'b1);
                        else if (grp == hosts_group)
                            queue_beat(1'b0, '0, '0, STAT_OK, 1'b1);
                        else
                        begin
                            held_timer[slot] = dly;
                            timers_live      = 1'b1;
                            queue_beat(1'b1, grp, ifc, STAT_OK, 1'b1);
                        end
                    end
                end
            end
            FN_LEAVE:
            begin
                slot = find_membership(grp, ifc);
                if (slot < 0)
                    queue_beat(1'b0, '0, '0, STAT_NOT_FOUND, 1'b1);
                else
                begin
                    held_valid[slot] = 1'b0;
                    held_timer[slot] = '0;
                    queue_beat(1'b0, '0, '0, STAT_OK, 1'b1);
                end
            end
            FN_TICK:
            begin
                if (timers_live)
                begin
                    timers_live = 1'b0;
                    for (i = 0; i < NUM_ENTRIES; i++)
                    begin
                        if (held_valid[i] && held_timer[i] != '0)
                        begin
                            held_timer[i] = held_timer[i] - 1'b1;
                            if (held_timer[i] == '0)
                            begin
                                queue_beat(1'b1, held_group[i], held_iface[i], STAT_OK, 1'b0);
                                fired++;
                            end
                            else
                                timers_live = 1'b1;
                        end
                    end
                end
                if (fired == 0)
                    queue_beat(1'b0, '0, '0, STAT_OK, 1'b1);
                else
                    expected_beats[expected_beats.size() - 1].last = 1'b1;
            end
            default:
                queue_beat(1'b0, '0, '0, STAT_OK, 1'b1);
        endcase
    endfunction

    task automatic check_field(input string name, input logic [GROUP_W-1:0] want,
                               input logic [GROUP_W-1:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        report_beat_t want;
        int i;
        if (!rst_n)
        begin
            hosts_group = ALL_HOSTS_RESET;
            lo_iface    = '0;
            for (i = 0; i < NUM_ENTRIES; i++)
            begin
                held_valid[i] = 1'b0;
                held_group[i] = '0;
                held_iface[i] = '0;
                held_timer[i] = '0;
            end
            timers_live = 1'b0;
            expected_beats.delete();
            errors  = 0;
            pending = 0;
        end
        else
        begin
            // register writes
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == CFG_ALL_HOSTS)
                    hosts_group = cfg.data;
                else if (cfg.index == CFG_LOOPBACK)
                    lo_iface = cfg.data[IFACE_W-1:0];
            end

            // compare a result beat with the oldest prediction
            if (result.valid && result.ready)
            begin
                if (expected_beats.size() == 0)
                begin
                    $error("result beat with nothing expected: report %0b group %0h status %0d",
                           result.is_report, result.report_group, result.status);
                    errors++;
                end
                else
                begin
                    want = expected_beats.pop_front();
                    check_field("is_report", GROUP_W'(want.is_report),
                                GROUP_W'(result.is_report));
                    check_field("report_group", want.group, result.report_group);
                    check_field("report_iface", GROUP_W'(want.iface),
                                GROUP_W'(result.report_iface));
                    check_field("status", GROUP_W'(want.status), GROUP_W'(result.status));
                    check_field("last", GROUP_W'(want.last), GROUP_W'(result.last));
                end
            end

            // predict the beats of an accepted item
            if (item.valid && item.ready)
                predict_membership(item.func, item.iface, item.group_addr, item.dst_addr,
                                   item.delay);

            pending = expected_beats.size();
        end
    end

endmodule

[bench/igmp_membership_report_timers_tb.sv]
`timescale 1ns / 1ps

module igmp_membership_report_timers_tb;
    import igmp_pkg::*;

    localparam int ENTRIES     = 16;
    localparam int CYCLE_LIMIT = 500000;
    localparam int PHASE_ITEMS = 90;

    // multicast groups that random items draw from, so joins, leaves and reports meet
    localparam logic [GROUP_W-1:0] GROUP_POOL = 32'hE100_0000;
    localparam logic [GROUP_W-1:0] GROUP_A    = 32'hE100_0005;
    localparam logic [GROUP_W-1:0] GROUP_B    = 32'hE100_0007;
    localparam logic [GROUP_W-1:0] GROUP_C    = 32'hEFFF_FFFE;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    int errors;
    int pending;
    int cycle_count = 0;
    int items_sent = 0;
    int beats_taken = 0;

    logic [GROUP_W-1:0] cur_all_hosts = ALL_HOSTS_RESET;
    logic [IFACE_W-1:0] cur_loopback = '0;

    igmp_cfg_if    cfg ();
    igmp_item_if   item ();
    igmp_result_if result ();

    igmp_membership_report_timers #(.ENTRIES(ENTRIES)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .item   (item),
        .result (result)
    );

    igmp_report_monitor #(.NUM_ENTRIES(ENTRIES)) report_check (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .item    (item),
        .result  (result),
        .errors  (errors),
        .pending (pending)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result side: random stalls per beat, with stretches of none
    initial
    begin
        int stall;
        result.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = ((beats_taken / 40) % 4 == 1) ? 0 : $urandom_range(0, 7);
            if (stall > 0)
            begin
                result.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result.ready <= 1'b1;
            @(posedge clk);
            while (!result.valid)
                @(posedge clk);
            beats_taken++;
        end
    end

    task automatic send_item(input logic [FUNC_W-1:0] fn, input logic [IFACE_W-1:0] ifc,
                             input logic [GROUP_W-1:0] grp, input logic [GROUP_W-1:0] dst,
                             input logic [DELAY_W-1:0] dly);
        int gap;
        gap = ((items_sent / 50) % 4 == 2) ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            item.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item.valid      <= 1'b1;
        item.func       <= fn;
        item.iface      <= ifc;
        item.group_addr <= grp;
        item.dst_addr   <= dst;
        item.delay      <= dly;
        @(posedge clk);
        while (!item.ready)
            @(posedge clk);
        items_sent++;
    endtask

    // hold the sender until every predicted beat has come back
    task automatic wait_drained();
        item.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [GROUP_W-1:0] data);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= data;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
    endtask

    task automatic set_config(input logic [GROUP_W-1:0] hosts, input logic [IFACE_W-1:0] lo);
        wait_drained();
        write_reg(CFG_ALL_HOSTS, hosts);
        // upper data bits are don't-care for the loopback register
        write_reg(CFG_LOOPBACK, {(GROUP_W - IFACE_W)'($urandom_range(0, 32'h0FFF_FFFF)), lo});
        cfg.valid <= 1'b0;
        cur_all_hosts = hosts;
        cur_loopback  = lo;
    endtask

    // mostly well-formed traffic on a small set of groups and interfaces, plus noise
    task automatic send_random();
        logic [FUNC_W-1:0]  fn;
        logic [IFACE_W-1:0] ifc;
        logic [GROUP_W-1:0] grp;
        logic [GROUP_W-1:0] dst;
        logic [DELAY_W-1:0] dly;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            fn = FN_TICK;
        else if (pick < 55)
            fn = FN_JOIN;
        else if (pick < 70)
            fn = FN_QUERY;
        else if (pick < 85)
            fn = FN_REPORT;
        else if (pick < 95)
            fn = FN_LEAVE;
        else
            fn = FN_TICK + FUNC_W'($urandom_range(1, 3));

        pick = $urandom_range(0, 9);
        if (pick == 0)
            ifc = cur_loopback;
        else if (pick < 3)
            ifc = IFACE_W'($urandom_range(0, 15));
        else
            ifc = IFACE_W'($urandom_range(0, 3));

        pick = $urandom_range(0, 9);
        if (pick == 0)
            grp = $urandom;
        else if (pick == 1)
            grp = cur_all_hosts;
        else
            grp = GROUP_POOL | GROUP_W'($urandom_range(0, 7));

        case (fn)
            FN_QUERY:  dst = ($urandom_range(0, 7) == 0) ? GROUP_W'($urandom) : cur_all_hosts;
            FN_REPORT: dst = ($urandom_range(0, 7) == 0) ? GROUP_W'($urandom) : grp;
            default:   dst = $urandom;
        endcase

        pick = $urandom_range(0, 9);
        if (pick < 6)
            dly = DELAY_W'($urandom_range(1, 4));
        else if (pick < 8)
            dly = '0;
        else
            dly = DELAY_W'($urandom_range(0, 63));

        send_item(fn, ifc, grp, dst, dly);
    endtask

    initial
    begin
        int i;
        item.valid      = 1'b0;
        item.func       = FN_QUERY;
        item.iface      = '0;
        item.group_addr = '0;
        item.dst_addr   = '0;
        item.delay      = '0;
        cfg.valid       = 1'b0;
        cfg.index       = CFG_ALL_HOSTS;
        cfg.data        = '0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset settings, all-hosts 224.0.0.1 and loopback 0
        send_item(FN_TICK,   4'd0,  '0,             '0,              6'd0);
        send_item(FN_JOIN,   4'd3,  GROUP_A,        '0,              6'd0);
        send_item(FN_JOIN,   4'd3,  GROUP_A,        '0,              6'd9);
        send_item(FN_JOIN,   4'd2,  ALL_HOSTS_RESET, '0,             6'd5);
        send_item(FN_JOIN,   4'd15, 32'hFFFF_FFFF,  32'hFFFF_FFFF,   6'd63);
        send_item(FN_JOIN,   4'd0,  32'h0000_0000,  '0,              6'd3);
        send_item(FN_TICK,   4'd7,  '0,             '0,              6'd1);
        send_item(FN_QUERY,  4'd0,  '0,             ALL_HOSTS_RESET, 6'd4);
        send_item(FN_QUERY,  4'd3,  '0,             32'hE000_0002,   6'd4);
        send_item(FN_QUERY,  4'd3,  GROUP_A,        ALL_HOSTS_RESET, 6'd63);
        send_item(FN_REPORT, 4'd3,  32'h7100_0005,  32'h7100_0005,   6'd2);
        send_item(FN_REPORT, 4'd3,  GROUP_A,        32'hE100_0006,   6'd2);
        send_item(FN_REPORT, 4'd3,  GROUP_A,        GROUP_A,         6'd2);
        send_item(FN_REPORT, 4'd4,  GROUP_B,        GROUP_B,         6'd2);
        send_item(FN_REPORT, 4'd0,  GROUP_A,        GROUP_A,         6'd2);
        send_item(FN_LEAVE,  4'd4,  GROUP_B,        '0,              6'd1);
        send_item(FN_LEAVE,  4'd0,  32'h0000_0000,  '0,              6'd1);
        for (i = 1; i <= 3; i++)
            send_item(FN_TICK + FUNC_W'(i), 4'd5, 32'h5555_AAAA, 32'hAAAA_5555, 6'd21);
        send_item(FN_JOIN,   4'd1,  GROUP_B,        '0,              6'd1);
        send_item(FN_JOIN,   4'd1,  GROUP_C,        '0,              6'd1);
        send_item(FN_TICK,   4'd1,  '0,             '0,              6'd1);
        send_item(FN_QUERY,  4'd15, '0,             ALL_HOSTS_RESET, 6'd2);
        send_item(FN_LEAVE,  4'd15, 32'hFFFF_FFFF,  '0,              6'd1);

        // random traffic under reset settings
        for (i = 0; i < PHASE_ITEMS; i++)
            send_random();

        // all-ones all-hosts group, top loopback interface
        set_config(32'hFFFF_FFFF, 4'd15);
        for (i = 0; i < PHASE_ITEMS; i++)
            send_random();

        // fill the table past capacity, then empty that interface again
        set_config(32'h0000_0000, 4'd7);
        for (i = 0; i < ENTRIES + 2; i++)
            send_item(FN_JOIN, 4'd9, GROUP_POOL | GROUP_W'(16 + i), '0,
                      DELAY_W'($urandom_range(1, 63)));
        for (i = 0; i < ENTRIES + 2; i++)
            send_item(FN_LEAVE, 4'd9, GROUP_POOL | GROUP_W'(16 + i), '0, 6'd1);
        for (i = 0; i < PHASE_ITEMS; i++)
            send_random();

        // back to the defaults, with a full drain halfway through
        set_config(ALL_HOSTS_RESET, 4'd0);
        for (i = 0; i < PHASE_ITEMS; i++)
        begin
            if (i == PHASE_ITEMS / 2)
                wait_drained();
            send_random();
        end

        wait_drained();
        repeat (ENTRIES + 8) @(posedge clk);

        if (errors == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
